// ===== src/htlp_pkg.sv =====
// Shared types, constants and hash function of the hash table core.
package htlp_pkg;

   localparam int SLOTS      = 16384;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int KEY_W      = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [63:0] HASH_MUL_DEV   = 64'd2654435761;
   localparam logic [63:0] HASH_MUL_INODE = 64'd2246822519;
   localparam int          FOLD_SHIFT     = 32;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MARK_EMPTY = 2'd0,
      MARK_USED  = 2'd1,
      MARK_TOMB  = 2'd2,
      MARK_BAD   = 2'd3
   } mark_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_READ,
      BK_CHECK,
      BK_DONE
   } bk_state_type;

   // Item travelling from front to back: classified op, key, payload, home slot.
   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  dev_key;
      logic [KEY_W-1:0]  ino_key;
      logic [KEY_W-1:0]  value_in;
      logic [IDX_W-1:0]  home;
   } job_type;

   // Reduce a folded hash modulo SLOTS by repeated compare and subtract in 32-bit
   // chunks is not needed when SLOTS is a power of two; this covers that case.
   function automatic logic [IDX_W-1:0] slot_of(input logic [63:0] f);
      logic [63:0] r;
      r = f % 64'(SLOTS);
      return r[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
      logic [IDX_W:0] n;
      n = {1'b0, s} + (IDX_W+1)'(1);
      if (n == (IDX_W+1)'(SLOTS)) begin
         n = '0;
      end
      return n[IDX_W-1:0];
   endfunction

endpackage

// ===== src/htlp_ram.sv =====
// Generic single-port RAM with registered read.
module htlp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry when enabled and read one entry a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/htlp_front.sv =====
// Front part: accepts items, computes the home slot over two stages.
module htlp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_dev_key,
   input  logic [63:0]         req_ino_key,
   input  logic [63:0]         req_value_in,
   output logic                job_valid,
   input  logic                job_ready,
   output htlp_pkg::job_type   job
);
   import htlp_pkg::*;

   // Stage 1: 32 by 32 partial products registered
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_pd_lo_ff, s1_pi_lo_ff;
   logic [31:0] s1_pd_hi_ff, s1_pi_hi_ff;
   logic [1:0]  s1_op_ff;
   logic [63:0] s1_dev_ff, s1_ino_ff, s1_val_ff;
   // Stage 2: folded hash registered
   logic        s2_valid_ff, s2_valid_in;
   logic [63:0] s2_fold_ff;
   logic [1:0]  s2_op_ff;
   logic [63:0] s2_dev_ff, s2_ino_ff, s2_val_ff;
   logic [63:0] hash;
   logic        s2_take, s1_take;

   assign s2_take   = !s2_valid_ff || job_ready;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign req_ready = s1_take;

   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s2_take);
   assign s2_valid_in = (s1_valid_ff && s2_take) || (s2_valid_ff && !job_ready);
   // Multipliers fit in 32 bits, so the high key half only adds its low product bits
   assign hash        = (s1_pd_lo_ff + {s1_pd_hi_ff, 32'd0}) ^
                        (s1_pi_lo_ff + {s1_pi_hi_ff, 32'd0});

   // Advance valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Hold or load stage payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_pd_lo_ff <= {32'd0, req_dev_key[31:0]} * {32'd0, HASH_MUL_DEV[31:0]};
         s1_pd_hi_ff <= req_dev_key[63:32] * HASH_MUL_DEV[31:0];
         s1_pi_lo_ff <= {32'd0, req_ino_key[31:0]} * {32'd0, HASH_MUL_INODE[31:0]};
         s1_pi_hi_ff <= req_ino_key[63:32] * HASH_MUL_INODE[31:0];
         s1_op_ff    <= req_op;
         s1_dev_ff   <= req_dev_key;
         s1_ino_ff   <= req_ino_key;
         s1_val_ff   <= req_value_in;
      end
      if (s1_valid_ff && s2_take) begin
         s2_fold_ff <= hash ^ (hash >> FOLD_SHIFT);
         s2_op_ff   <= s1_op_ff;
         s2_dev_ff  <= s1_dev_ff;
         s2_ino_ff  <= s1_ino_ff;
         s2_val_ff  <= s1_val_ff;
      end
   end

   assign job_valid     = s2_valid_ff;
   assign job.op        = op_type'(s2_op_ff);
   assign job.dev_key   = s2_dev_ff;
   assign job.ino_key   = s2_ino_ff;
   assign job.value_in  = s2_val_ff;
   assign job.home      = slot_of(s2_fold_ff);

endmodule

// ===== src/htlp_queue.sv =====
// Short queue between front and back parts.
module htlp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  htlp_pkg::job_type in_job,
   output logic              out_valid,
   input  logic              out_ready,
   output htlp_pkg::job_type out_job
);
   import htlp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]       count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != (PTR_W+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_job   = entry_ff[rd_ptr_ff];
   assign count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// ===== src/htlp_back.sv =====
// Back part: clears the marks after reset, probes the slot memories, applies the op and holds the result.
module htlp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  htlp_pkg::job_type job,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [63:0]       rsp_value_out
);
   import htlp_pkg::*;

   bk_state_type      state_ff, state_in;
   job_type           job_ff, job_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              have_tomb_ff, have_tomb_in;
   logic [IDX_W-1:0]  tomb_ff, tomb_in;
   logic [1:0]        status_ff, status_in;
   logic [63:0]       value_ff, value_in;

   logic              mark_we, data_we, value_we;
   logic [IDX_W-1:0]  addr;
   logic [1:0]        mark_wd, mark_rd;
   logic [63:0]       dev_rd, ino_rd, val_rd;
   logic              key_hit, clear_last;

   htlp_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mark (
      .clock(clock), .wr_en(mark_we), .addr(addr), .wr_data(mark_wd), .rd_data(mark_rd));
   htlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_dev (
      .clock(clock), .wr_en(data_we), .addr(addr), .wr_data(job_ff.dev_key),
      .rd_data(dev_rd));
   htlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_inode (
      .clock(clock), .wr_en(data_we), .addr(addr), .wr_data(job_ff.ino_key),
      .rd_data(ino_rd));
   htlp_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_value (
      .clock(clock), .wr_en(value_we), .addr(addr), .wr_data(job_ff.value_in),
      .rd_data(val_rd));

   assign key_hit    = mark_rd == MARK_USED && dev_rd == job_ff.dev_key &&
                       ino_rd == job_ff.ino_key;
   assign clear_last = slot_ff == IDX_W'(SLOTS - 1);
   assign rsp_valid     = state_ff == BK_DONE;
   assign rsp_status    = status_ff;
   assign rsp_value_out = value_ff;

   // State and payload registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_CLEAR;
         slot_ff  <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff  <= slot_in;
      end
      job_ff       <= job_in;
      left_ff      <= left_in;
      have_tomb_ff <= have_tomb_in;
      tomb_ff      <= tomb_in;
      status_ff    <= status_in;
      value_ff     <= value_in;
   end

   // Next state: clear marks, read a slot, check it, write and report
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      slot_in      = slot_ff;
      left_in      = left_ff;
      have_tomb_in = have_tomb_ff;
      tomb_in      = tomb_ff;
      status_in    = status_ff;
      value_in     = value_ff;
      job_ready    = 1'b0;
      mark_we      = 1'b0;
      data_we      = 1'b0;
      value_we     = 1'b0;
      mark_wd      = MARK_EMPTY;
      addr         = slot_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            mark_we = 1'b1;
            slot_in = next_slot(slot_ff);
            if (clear_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               job_in       = job;
               slot_in      = job.home;
               left_in      = CNT_W'(SLOTS);
               have_tomb_in = 1'b0;
               value_in     = '0;
               if (job.op == OP_NONE) begin
                  status_in = ST_MISS;
                  state_in  = BK_DONE;
               end else begin
                  state_in = BK_READ;
               end
            end
         end
         BK_READ: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            state_in = BK_DONE;
            status_in = ST_OK;
            if (mark_rd == MARK_EMPTY) begin
               if (job_ff.op == OP_PUT) begin
                  addr     = have_tomb_ff ? tomb_ff : slot_ff;
                  mark_we  = 1'b1;
                  mark_wd  = MARK_USED;
                  data_we  = 1'b1;
                  value_we = 1'b1;
               end else begin
                  status_in = ST_MISS;
               end
            end else if (key_hit) begin
               unique case (job_ff.op)
                  OP_PUT:    value_we = 1'b1;
                  OP_GET:    value_in = val_rd;
                  OP_REMOVE: begin
                     mark_we = 1'b1;
                     mark_wd = MARK_TOMB;
                  end
                  default:   status_in = ST_MISS;
               endcase
            end else begin
               if (mark_rd == MARK_TOMB && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in      = slot_ff;
               end
               if (left_ff == CNT_W'(1)) begin
                  // Probe wrapped fully
                  if (job_ff.op == OP_PUT && (have_tomb_ff || mark_rd == MARK_TOMB)) begin
                     addr     = have_tomb_ff ? tomb_ff : slot_ff;
                     mark_we  = 1'b1;
                     mark_wd  = MARK_USED;
                     data_we  = 1'b1;
                     value_we = 1'b1;
                  end else begin
                     status_in = (job_ff.op == OP_PUT) ? ST_FULL : ST_MISS;
                  end
               end else begin
                  slot_in  = next_slot(slot_ff);
                  left_in  = left_ff - CNT_W'(1);
                  state_in = BK_READ;
               end
            end
         end
         BK_DONE: begin
            if (rsp_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

endmodule

// ===== src/hash_table_linear_probe_tombstone_core.sv =====
// Top level of the linear-probing hash table with tombstones.
//
// Items enter on the req_ channel (op, dev_key, ino_key, value_in) and each
// gives exactly one item on the rsp_ channel (status, value_out), in order.
// Both channels use valid/ready; an item moves when valid and ready are high.
// The front part multiplies and folds the key over two register stages and
// passes the item through a two-entry queue to the back part, so it keeps
// accepting while the back part probes or a result waits.
// The back part probes each slot in two states, BK_READ (one memory read) and
// BK_CHECK (one check), after taking an item in BK_IDLE, and reports the
// result in BK_DONE. The back part handles one item at a time, so it takes
// no new item until the result of the last one has been taken.
// The slot marks live in one memory port shared by probe and write.
// After reset the back part clears all SLOTS marks, one per cycle; items
// queue in the front meanwhile. A stalled rsp_ready holds the result and
// stops the back part; the front fills, then drops req_ready.
module hash_table_linear_probe_tombstone_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_dev_key,
   input  logic [63:0] req_ino_key,
   input  logic [63:0] req_value_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_value_out
);
   import htlp_pkg::*;

   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   job_type fq_job, qb_job;

   htlp_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_dev_key(req_dev_key), .req_ino_key(req_ino_key),
      .req_value_in(req_value_in),
      .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job));

   htlp_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(fq_valid), .in_ready(fq_ready), .in_job(fq_job),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_job(qb_job));

   htlp_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_value_out(rsp_value_out));

   // Value is zero on a miss or full result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value_out == '0)
      else $error("nonzero value on miss or full");

   // Status code never invalid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_MISS ||
      rsp_status == ST_FULL)
      else $error("bad status code");

   // Result held while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_value_out))
      else $error("result changed under stall");

endmodule
